// ===== hdl/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types, widths, constants and helpers of the circle collision block.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MASS_FRAC     = 28;
  localparam int BOUNCE_SHIFT  = 16;

  localparam int POS_W = 32;
  localparam int MASS_W = 32;
  localparam int BNC_W = 17;
  localparam int RAD_W = 31;

  localparam logic [BNC_W-1:0] BOUNCE_ONE = BNC_W'(65536);

  // working value width for updated positions and velocities
  localparam int WK_W = 40;
  // multiplier operand and product widths
  localparam int K_W = 38;
  localparam int MB_W = 33;
  localparam int P_W = K_W + MB_W;
  // divider and root unit widths
  localparam int DEN_W = 33;
  localparam int SQ_W = 64;
  localparam int ROOT_W = 32;
  localparam int CNT_W = 6;
  localparam int SQRT_ITER = 32;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ccr_req_t;

  function automatic logic [POS_W-1:0] sat32(input logic signed [WK_W-1:0] v);
    logic signed [WK_W-1:0] hi;
    logic signed [WK_W-1:0] lo;
    hi = {{(WK_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    lo = {{(WK_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
    if (v > hi) begin
      return hi[POS_W-1:0];
    end else if (v < lo) begin
      return lo[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/ccr_mul.sv =====
// ----------------------------------------------------------------------------
// ccr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ccr_mul
  import ccr_pkg::*;
(
  input  logic                  clk,
  input  logic signed [K_W-1:0]  mul_a,
  input  logic signed [MB_W-1:0] mul_b,
  output logic signed [P_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= P_W'(mul_a) * P_W'(mul_b);
  end

endmodule

// ===== hdl/ccr_divsqrt.sv =====
// ----------------------------------------------------------------------------
// ccr_divsqrt
// Iterative unit: bitwise integer square root or restoring division,
// one step per cycle on a shared subtractor.
// ----------------------------------------------------------------------------
module ccr_divsqrt
  import ccr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ccr_req_t          req,
  input  logic [SQ_W-1:0]   acc_in,
  input  logic [SQ_W-1:0]   bit_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [CNT_W-1:0]  iter_in,
  output logic              busy,
  output logic              done,
  output logic [SQ_W-1:0]   res
);

  logic [SQ_W-1:0]  acc_r, acc_nxt;
  logic [SQ_W-1:0]  aux_r, aux_nxt;
  logic [SQ_W-1:0]  bit_r, bit_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             mode_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem2;
  logic [SQ_W-1:0]  sub_a, sub_b;
  logic [SQ_W:0]    diff;
  logic             ge;

  always_comb begin
    rem2  = {acc_r[DEN_W-1:0], bit_r[SQ_W-1]};
    sub_a = mode_r ? acc_r : {{(SQ_W-DEN_W-1){1'b0}}, rem2};
    sub_b = mode_r ? (aux_r + bit_r) : {{(SQ_W-DEN_W){1'b0}}, den_r};
    diff  = {1'b0, sub_a} - {1'b0, sub_b};
    ge    = !diff[SQ_W];
    if (mode_r) begin
      acc_nxt = ge ? diff[SQ_W-1:0] : acc_r;
      aux_nxt = ge ? ((aux_r >> 1) + bit_r) : (aux_r >> 1);
      bit_nxt = bit_r >> 2;
    end else begin
      acc_nxt = ge ? diff[SQ_W-1:0] : {{(SQ_W-DEN_W-1){1'b0}}, rem2};
      aux_nxt = {aux_r[SQ_W-2:0], ge};
      bit_nxt = bit_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r  <= acc_in;
      aux_r  <= '0;
      bit_r  <= bit_in;
      den_r  <= den_in;
      cnt_r  <= iter_in;
      mode_r <= req.sqrt_mode;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      aux_r <= aux_nxt;
      bit_r <= bit_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = aux_r;

endmodule

// ===== hdl/circle_collision_response.sv =====
// A first-of-pair body is taken into the held register and gives no result.
// A second-of-pair body is resolved before both results are offered: a bitwise root on the
// shared divide/root unit, then, only with contact, four divisions on the same unit.
// One pair is in work at a time; in_ready is low until the B result is in the output register.
// Reset (synchronous, active low) empties the held body and the output register.
// ----------------------------------------------------------------------------
// circle_collision_response
// Two-body circle contact resolution: normal velocity exchange with
// restitution and mass-weighted separation, in Q-format fixed point.
// ----------------------------------------------------------------------------
module circle_collision_response
  import ccr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_second_of_pair,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_vel_x,
  input  logic signed [POS_W-1:0] in_vel_y,
  input  logic [MASS_W-1:0]       in_mass,
  input  logic [BNC_W-1:0]        in_bounce,
  input  logic [RAD_W-1:0]        in_radius,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_body_select,
  output logic signed [POS_W-1:0] out_new_pos_x,
  output logic signed [POS_W-1:0] out_new_pos_y,
  output logic signed [POS_W-1:0] out_new_vel_x,
  output logic signed [POS_W-1:0] out_new_vel_y,
  output logic                    out_collided,
  output logic                    out_last_result
);

  localparam int NQ  = FRAC_BITS + 2;
  localparam int N_W = FRAC_BITS + 3;
  localparam int OV_W = RAD_W + 4;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_DIFF = 6'd1;
  localparam logic [5:0] S_SQX  = 6'd2;
  localparam logic [5:0] S_SQY  = 6'd3;
  localparam logic [5:0] S_SQS  = 6'd4;
  localparam logic [5:0] S_SQW  = 6'd5;
  localparam logic [5:0] S_NXS  = 6'd6;
  localparam logic [5:0] S_NXW  = 6'd7;
  localparam logic [5:0] S_NYS  = 6'd8;
  localparam logic [5:0] S_NYW  = 6'd9;
  localparam logic [5:0] S_FAS  = 6'd10;
  localparam logic [5:0] S_FAW  = 6'd11;
  localparam logic [5:0] S_FBS  = 6'd12;
  localparam logic [5:0] S_FBW  = 6'd13;
  localparam logic [5:0] S_M1   = 6'd14;
  localparam logic [5:0] S_M2   = 6'd15;
  localparam logic [5:0] S_M3   = 6'd16;
  localparam logic [5:0] S_M4   = 6'd17;
  localparam logic [5:0] S_M5   = 6'd18;
  localparam logic [5:0] S_M6   = 6'd19;
  localparam logic [5:0] S_M7   = 6'd20;
  localparam logic [5:0] S_M8   = 6'd21;
  localparam logic [5:0] S_M9   = 6'd22;
  localparam logic [5:0] S_M10  = 6'd23;
  localparam logic [5:0] S_M11  = 6'd24;
  localparam logic [5:0] S_M12  = 6'd25;
  localparam logic [5:0] S_M13  = 6'd26;
  localparam logic [5:0] S_M14  = 6'd27;
  localparam logic [5:0] S_M15  = 6'd28;
  localparam logic [5:0] S_M16  = 6'd29;
  localparam logic [5:0] S_M17  = 6'd30;
  localparam logic [5:0] S_M18  = 6'd31;
  localparam logic [5:0] S_M19  = 6'd32;
  localparam logic [5:0] S_M20  = 6'd33;
  localparam logic [5:0] S_OUTA = 6'd34;
  localparam logic [5:0] S_OUTB = 6'd35;

  logic [5:0] state_r, state_nxt;

  // held body A
  logic signed [POS_W-1:0] h_px_r, h_py_r, h_vx_r, h_vy_r;
  logic [MASS_W-1:0]       h_m_r;
  logic [BNC_W-1:0]        h_bn_r;
  logic [RAD_W-1:0]        h_rad_r;
  logic                    held_valid_r;

  // pair being resolved
  logic signed [WK_W-1:0] a_px_r, a_py_r, a_vx_r, a_vy_r;
  logic signed [WK_W-1:0] b_px_r, b_py_r, b_vx_r, b_vy_r;
  logic [MASS_W-1:0]      m_a_r, m_b_r;
  logic [BNC_W-1:0]       bn_a_r, bn_b_r;
  logic [RAD_W-1:0]       rad_a_r, rad_b_r;

  logic                   dx_neg_r, dy_neg_r, shf_r;
  logic [POS_W:0]         adx_r, ady_r;
  logic [POS_W-1:0]       ux_r, uy_r;
  logic [SQ_W-1:0]        sq_r;
  logic [DEN_W-1:0]       dist_r;
  logic signed [OV_W-1:0] ovl_r;
  logic                   hit_r;
  logic signed [N_W-1:0]  nx_r, ny_r;
  logic [MASS_FRAC-1:0]   fa_r, fb_r;
  logic signed [P_W-1:0]  acc_r;
  logic signed [K_W-1:0]  s_r, j_r, ka_r, kb_r, qa_r, qb_r;
  logic [BNC_W:0]         bmul_r;

  // output register
  logic                   out_valid_r, out_sel_r, out_hit_r;
  logic [POS_W-1:0]       out_px_r, out_py_r, out_vx_r, out_vy_r;

  // conditioned input
  logic [MASS_W-1:0] m_in;
  logic [BNC_W-1:0]  bn_in;
  logic              in_acc;
  logic              out_free;

  // difference, root and division results
  logic signed [POS_W:0] dx_c, dy_c;
  logic [POS_W:0]        adx_c, ady_c;
  logic                  shf_c;
  logic [DEN_W-1:0]      dist_c;
  logic signed [OV_W-1:0] ovl_c;
  logic                  hit_c;
  logic [DEN_W-1:0]      msum;
  logic [NQ-1:0]         quo;
  logic signed [N_W-1:0] nq_c;

  // shared units
  ccr_req_t              div_req;
  logic [SQ_W-1:0]       div_acc, div_bit, div_res;
  logic [DEN_W-1:0]      div_den;
  logic [CNT_W-1:0]      div_iter;
  logic                  div_busy, div_done;
  logic signed [K_W-1:0]  mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  p_r;
  logic signed [P_W-1:0]  p_f, p_16, p_28, dot, dot_f;

  ccr_divsqrt u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .acc_in  (div_acc),
    .bit_in  (div_bit),
    .den_in  (div_den),
    .iter_in (div_iter),
    .busy    (div_busy),
    .done    (div_done),
    .res     (div_res)
  );

  ccr_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (p_r)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    m_in  = (in_mass == '0) ? MASS_W'(1) : in_mass;
    bn_in = (in_bounce > BOUNCE_ONE) ? BOUNCE_ONE : in_bounce;

    dx_c  = b_px_r[POS_W:0] - a_px_r[POS_W:0];
    dy_c  = b_py_r[POS_W:0] - a_py_r[POS_W:0];
    adx_c = dx_c[POS_W] ? -dx_c : dx_c;
    ady_c = dy_c[POS_W] ? -dy_c : dy_c;
    shf_c = adx_c[POS_W] | adx_c[POS_W-1] | ady_c[POS_W] | ady_c[POS_W-1];

    dist_c = shf_r ? {div_res[ROOT_W-1:0], 1'b0} : {1'b0, div_res[ROOT_W-1:0]};
    ovl_c  = $signed({4'b0, rad_a_r}) + $signed({4'b0, rad_b_r})
           - $signed({2'b0, dist_c});
    hit_c  = (dist_c != '0) && !ovl_c[OV_W-1] && (ovl_c != '0);

    msum = {1'b0, m_a_r} + {1'b0, m_b_r};
    quo  = div_res[NQ-1:0];
    // sign of the matching difference component, truncation toward zero
    if (state_r == S_NXW) begin
      nq_c = dx_neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end else begin
      nq_c = dy_neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    p_f   = p_r >>> FRAC_BITS;
    p_16  = p_r >>> BOUNCE_SHIFT;
    p_28  = p_r >>> MASS_FRAC;
    dot   = acc_r + p_r;
    dot_f = dot >>> FRAC_BITS;
  end

  // divide / root requests
  always_comb begin
    div_req  = '0;
    div_acc  = sq_r + p_r[SQ_W-1:0];
    div_bit  = SQ_W'(1) << (SQ_W - 2);
    div_den  = dist_r;
    div_iter = CNT_W'(SQRT_ITER);
    case (state_r)
      S_SQS: begin
        div_req.start     = 1'b1;
        div_req.sqrt_mode = 1'b1;
      end
      S_NXS: begin
        div_req.start = 1'b1;
        div_acc  = {{(SQ_W-POS_W+1){1'b0}}, adx_r[POS_W:2]};
        div_bit  = {adx_r[1:0], {(SQ_W-2){1'b0}}};
        div_iter = CNT_W'(NQ);
      end
      S_NYS: begin
        div_req.start = 1'b1;
        div_acc  = {{(SQ_W-POS_W+1){1'b0}}, ady_r[POS_W:2]};
        div_bit  = {ady_r[1:0], {(SQ_W-2){1'b0}}};
        div_iter = CNT_W'(NQ);
      end
      S_FAS: begin
        div_req.start = 1'b1;
        div_acc  = {{(SQ_W-MASS_W){1'b0}}, m_b_r};
        div_bit  = '0;
        div_den  = msum;
        div_iter = CNT_W'(MASS_FRAC);
      end
      S_FBS: begin
        div_req.start = 1'b1;
        div_acc  = {{(SQ_W-MASS_W){1'b0}}, m_a_r};
        div_bit  = '0;
        div_den  = msum;
        div_iter = CNT_W'(MASS_FRAC);
      end
      default: begin
      end
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX: begin
        mul_a = {{(K_W-POS_W){1'b0}}, ux_r};
        mul_b = {{(MB_W-POS_W){1'b0}}, ux_r};
      end
      S_SQY: begin
        mul_a = {{(K_W-POS_W){1'b0}}, uy_r};
        mul_b = {{(MB_W-POS_W){1'b0}}, uy_r};
      end
      S_M1: begin
        mul_a = a_vx_r[K_W-1:0] - b_vx_r[K_W-1:0];
        mul_b = {{(MB_W-N_W){nx_r[N_W-1]}}, nx_r};
      end
      S_M2: begin
        mul_a = a_vy_r[K_W-1:0] - b_vy_r[K_W-1:0];
        mul_b = {{(MB_W-N_W){ny_r[N_W-1]}}, ny_r};
      end
      S_M4: begin
        mul_a = {{(K_W-BNC_W){1'b0}}, bn_a_r};
        mul_b = {{(MB_W-BNC_W){1'b0}}, bn_b_r};
      end
      S_M6: begin
        mul_a = s_r;
        mul_b = {{(MB_W-BNC_W-1){1'b0}}, bmul_r};
      end
      S_M8: begin
        mul_a = j_r;
        mul_b = {{(MB_W-MASS_FRAC){1'b0}}, fa_r};
      end
      S_M9: begin
        mul_a = j_r;
        mul_b = {{(MB_W-MASS_FRAC){1'b0}}, fb_r};
      end
      S_M10: begin
        mul_a = {{(K_W-OV_W){ovl_r[OV_W-1]}}, ovl_r};
        mul_b = {{(MB_W-MASS_FRAC){1'b0}}, fa_r};
      end
      S_M11: begin
        mul_a = {{(K_W-OV_W){ovl_r[OV_W-1]}}, ovl_r};
        mul_b = {{(MB_W-MASS_FRAC){1'b0}}, fb_r};
      end
      S_M12: begin
        mul_a = ka_r;
        mul_b = {{(MB_W-N_W){nx_r[N_W-1]}}, nx_r};
      end
      S_M13: begin
        mul_a = ka_r;
        mul_b = {{(MB_W-N_W){ny_r[N_W-1]}}, ny_r};
      end
      S_M14: begin
        mul_a = kb_r;
        mul_b = {{(MB_W-N_W){nx_r[N_W-1]}}, nx_r};
      end
      S_M15: begin
        mul_a = kb_r;
        mul_b = {{(MB_W-N_W){ny_r[N_W-1]}}, ny_r};
      end
      S_M16: begin
        mul_a = qa_r;
        mul_b = {{(MB_W-N_W){nx_r[N_W-1]}}, nx_r};
      end
      S_M17: begin
        mul_a = qa_r;
        mul_b = {{(MB_W-N_W){ny_r[N_W-1]}}, ny_r};
      end
      S_M18: begin
        mul_a = qb_r;
        mul_b = {{(MB_W-N_W){nx_r[N_W-1]}}, nx_r};
      end
      S_M19: begin
        mul_a = qb_r;
        mul_b = {{(MB_W-N_W){ny_r[N_W-1]}}, ny_r};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_second_of_pair) begin
          state_nxt = held_valid_r ? S_DIFF : S_OUTB;
        end
      end
      S_SQW: begin
        if (div_done) begin
          state_nxt = hit_c ? S_NXS : S_OUTA;
        end
      end
      S_NXW: begin
        if (div_done) begin
          state_nxt = S_NYS;
        end
      end
      S_NYW: begin
        if (div_done) begin
          state_nxt = S_FAS;
        end
      end
      S_FAW: begin
        if (div_done) begin
          state_nxt = S_FBS;
        end
      end
      S_FBW: begin
        if (div_done) begin
          state_nxt = S_M1;
        end
      end
      S_M20: begin
        state_nxt = S_OUTA;
      end
      S_OUTA: begin
        if (out_free) begin
          state_nxt = S_OUTB;
        end
      end
      S_OUTB: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = state_r + 6'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        held_valid_r <= !in_second_of_pair;
      end
      if ((state_r == S_OUTA || state_r == S_OUTB) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_second_of_pair) begin
          h_px_r  <= in_pos_x;
          h_py_r  <= in_pos_y;
          h_vx_r  <= in_vel_x;
          h_vy_r  <= in_vel_y;
          h_m_r   <= m_in;
          h_bn_r  <= bn_in;
          h_rad_r <= in_radius;
        end
        if (in_acc && in_second_of_pair) begin
          a_px_r  <= {{(WK_W-POS_W){h_px_r[POS_W-1]}}, h_px_r};
          a_py_r  <= {{(WK_W-POS_W){h_py_r[POS_W-1]}}, h_py_r};
          a_vx_r  <= {{(WK_W-POS_W){h_vx_r[POS_W-1]}}, h_vx_r};
          a_vy_r  <= {{(WK_W-POS_W){h_vy_r[POS_W-1]}}, h_vy_r};
          m_a_r   <= h_m_r;
          bn_a_r  <= h_bn_r;
          rad_a_r <= h_rad_r;
          b_px_r  <= {{(WK_W-POS_W){in_pos_x[POS_W-1]}}, in_pos_x};
          b_py_r  <= {{(WK_W-POS_W){in_pos_y[POS_W-1]}}, in_pos_y};
          b_vx_r  <= {{(WK_W-POS_W){in_vel_x[POS_W-1]}}, in_vel_x};
          b_vy_r  <= {{(WK_W-POS_W){in_vel_y[POS_W-1]}}, in_vel_y};
          m_b_r   <= m_in;
          bn_b_r  <= bn_in;
          rad_b_r <= in_radius;
          hit_r   <= 1'b0;
        end
      end
      S_DIFF: begin
        dx_neg_r <= dx_c[POS_W];
        dy_neg_r <= dy_c[POS_W];
        adx_r    <= adx_c;
        ady_r    <= ady_c;
        shf_r    <= shf_c;
        // halve both components when either does not fit 31 bits
        ux_r     <= shf_c ? adx_c[POS_W:1] : adx_c[POS_W-1:0];
        uy_r     <= shf_c ? ady_c[POS_W:1] : ady_c[POS_W-1:0];
      end
      S_SQY: begin
        sq_r <= p_r[SQ_W-1:0];
      end
      S_SQW: begin
        if (div_done) begin
          dist_r <= dist_c;
          ovl_r  <= ovl_c;
          hit_r  <= hit_c;
        end
      end
      S_NXW: begin
        if (div_done) begin
          nx_r <= nq_c;
        end
      end
      S_NYW: begin
        if (div_done) begin
          ny_r <= nq_c;
        end
      end
      S_FAW: begin
        if (div_done) begin
          fa_r <= div_res[MASS_FRAC-1:0];
        end
      end
      S_FBW: begin
        if (div_done) begin
          fb_r <= div_res[MASS_FRAC-1:0];
        end
      end
      S_M2:  acc_r  <= p_r;
      S_M3:  s_r    <= dot_f[K_W-1:0];
      S_M5:  bmul_r <= {1'b0, BOUNCE_ONE} + {1'b0, p_r[BNC_W+BOUNCE_SHIFT-1:BOUNCE_SHIFT]};
      S_M7:  j_r    <= p_16[K_W-1:0];
      S_M9:  ka_r   <= p_28[K_W-1:0];
      S_M10: kb_r   <= p_28[K_W-1:0];
      S_M11: qa_r   <= p_28[K_W-1:0];
      S_M12: qb_r   <= p_28[K_W-1:0];
      S_M13: a_vx_r <= a_vx_r - p_f[WK_W-1:0];
      S_M14: a_vy_r <= a_vy_r - p_f[WK_W-1:0];
      S_M15: b_vx_r <= b_vx_r + p_f[WK_W-1:0];
      S_M16: b_vy_r <= b_vy_r + p_f[WK_W-1:0];
      S_M17: a_px_r <= a_px_r - p_f[WK_W-1:0];
      S_M18: a_py_r <= a_py_r - p_f[WK_W-1:0];
      S_M19: b_px_r <= b_px_r + p_f[WK_W-1:0];
      S_M20: b_py_r <= b_py_r + p_f[WK_W-1:0];
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_OUTA && out_free) begin
      out_sel_r <= 1'b0;
      out_px_r  <= sat32(a_px_r);
      out_py_r  <= sat32(a_py_r);
      out_vx_r  <= sat32(a_vx_r);
      out_vy_r  <= sat32(a_vy_r);
      out_hit_r <= hit_r;
    end else if (state_r == S_OUTB && out_free) begin
      out_sel_r <= 1'b1;
      out_px_r  <= sat32(b_px_r);
      out_py_r  <= sat32(b_py_r);
      out_vx_r  <= sat32(b_vx_r);
      out_vy_r  <= sat32(b_vy_r);
      out_hit_r <= hit_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_body_select = out_sel_r;
  assign out_new_pos_x   = out_px_r;
  assign out_new_pos_y   = out_py_r;
  assign out_new_vel_x   = out_vx_r;
  assign out_new_vel_y   = out_vy_r;
  assign out_collided    = out_hit_r;
  assign out_last_result = out_sel_r;

  a_last_marks_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_body_select == out_last_result))
    else $error("last_result does not match body_select");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SQW || state_r == S_NXW || state_r == S_NYW ||
                  state_r == S_FAW || state_r == S_FBW))
    else $error("divide/root unit finished outside a wait step");

  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("ready while divide/root unit busy");

  a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_second_of_pair) |=> !held_valid_r)
    else $error("held body not released after second request");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle collision response testbench
// Drives body pairs, lone bodies and replaced bodies through the request
// channel, predicts both contact results in fixed point and checks each
// result field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import ccr_pkg::*;

  typedef struct {
    logic        second;
    logic [31:0] px, py, vx, vy;
    logic [31:0] mass;
    logic [16:0] bounce;
    logic [30:0] radius;
  } body_t;

  typedef struct {
    logic        sel;
    logic [31:0] px, py, vx, vy;
    logic        hit;
    logic        last;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_second_of_pair = 1'b0;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic [MASS_W-1:0] in_mass = '0;
  logic [BNC_W-1:0] in_bounce = '0;
  logic [RAD_W-1:0] in_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_body_select, out_collided, out_last_result;
  logic signed [POS_W-1:0] out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y;

  body_t    bodies_q[$];
  contact_t contacts_q[$];
  int       total_bodies;
  int       sent_bodies = 0;
  int       errors = 0;
  int       src_idle_pct = 0;
  int       snk_stall_pct = 0;

  // held body A
  longint   a_px, a_py, a_vx, a_vy;
  longint   a_mass, a_bounce, a_radius;
  bit       a_held = 0;

  circle_collision_response u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic contact_t mk(logic s, longint px, longint py, longint vx, longint vy,
                                  logic h);
    contact_t c;
    c.sel = s; c.last = s; c.hit = h;
    c.px = clamp32(px); c.py = clamp32(py);
    c.vx = clamp32(vx); c.vy = clamp32(vy);
    return c;
  endfunction

  task automatic resolve_contact(body_t b);
    longint px, py, vx, vy, m, e_in, r;
    longint dx, dy, dst, ovl, nx, ny, s, e, ka, kb, qa, qb, msum, fa, fb;
    longint unsigned ux, uy;
    logic signed [127:0] j, t;
    bit sh, hit;
    px = sx32(b.px); py = sx32(b.py); vx = sx32(b.vx); vy = sx32(b.vy);
    m = b.mass == 0 ? 1 : longint'(b.mass);
    e_in = b.bounce > 17'd65536 ? 65536 : longint'(b.bounce);
    r = longint'(b.radius);
    if (!b.second) begin
      a_px = px; a_py = py; a_vx = vx; a_vy = vy;
      a_mass = m; a_bounce = e_in; a_radius = r; a_held = 1;
      return;
    end
    if (!a_held) begin
      contacts_q.push_back(mk(1'b1, px, py, vx, vy, 1'b0));
      return;
    end
    a_held = 0;
    dx = px - a_px; dy = py - a_py;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    sh = ux >= (64'd1 << 31) || uy >= (64'd1 << 31);
    if (sh) begin ux >>= 1; uy >>= 1; end
    dst = root64(ux * ux + uy * uy) << sh;
    ovl = a_radius + r - dst;
    hit = dst > 0 && ovl > 0;
    if (hit) begin
      nx = dx * 65536 / dst;
      ny = dy * 65536 / dst;
      s = ((a_vx - vx) * nx + (a_vy - vy) * ny) >>> 16;
      e = (a_bounce * e_in) >>> 16;
      j = (128'(s) * (65536 + e)) >>> 16;
      msum = a_mass + m;
      fa = (m << 28) / msum;
      fb = (a_mass << 28) / msum;
      t = (j * fa) >>> 28; ka = t[63:0];
      t = (j * fb) >>> 28; kb = t[63:0];
      qa = (ovl * fa) >>> 28;
      qb = (ovl * fb) >>> 28;
      a_vx -= (ka * nx) >>> 16;
      a_vy -= (ka * ny) >>> 16;
      vx += (kb * nx) >>> 16;
      vy += (kb * ny) >>> 16;
      a_px -= (qa * nx) >>> 16;
      a_py -= (qa * ny) >>> 16;
      px += (qb * nx) >>> 16;
      py += (qb * ny) >>> 16;
    end
    contacts_q.push_back(mk(1'b0, a_px, a_py, a_vx, a_vy, hit));
    contacts_q.push_back(mk(1'b1, px, py, vx, vy, hit));
  endtask

  function automatic logic [31:0] rnd_coord(logic [31:0] base, int span);
    return base + 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic body_t rnd_body(logic second, logic [31:0] cx, logic [31:0] cy);
    body_t b;
    int k;
    b.second = second;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      b.px = $urandom(); b.py = $urandom(); b.vx = $urandom(); b.vy = $urandom();
      b.radius = 31'($urandom());
    end else begin
      b.px = rnd_coord(cx, 1 << 18); b.py = rnd_coord(cy, 1 << 18);
      b.vx = rnd_coord(0, 1 << 21); b.vy = rnd_coord(0, 1 << 21);
      b.radius = 31'($urandom_range(0, 1 << 18));
    end
    k = $urandom_range(0, 9);
    b.mass = k == 0 ? 32'd0 : k == 1 ? $urandom() : 32'($urandom_range(1, 1 << 20));
    b.bounce = $urandom_range(0, 3) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    return b;
  endfunction

  function automatic body_t fixed_body(logic s, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] vx, logic [31:0] vy, logic [31:0] m,
                                       logic [16:0] bn, logic [30:0] r);
    body_t b;
    b.second = s; b.px = px; b.py = py; b.vx = vx; b.vy = vy;
    b.mass = m; b.bounce = bn; b.radius = r;
    return b;
  endfunction

  initial begin
    logic [31:0] cx, cy;
    int k;
    // lone B right after reset
    bodies_q.push_back(fixed_body(1, 32'h10000, 0, 32'h20000, 0, 32'h10000, 0, 32'h10000));
    // zero distance pair
    bodies_q.push_back(fixed_body(0, 32'h5000, 32'h5000, 0, 0, 0, 17'h1ffff, 32'h10000));
    bodies_q.push_back(fixed_body(1, 32'h5000, 32'h5000, 32'h100, 0, 1, 65536, 32'h10000));
    // head-on contact, equal masses, full bounce
    bodies_q.push_back(fixed_body(0, 0, 0, 32'h10000, 0, 32'h10000, 65536, 32'h10000));
    bodies_q.push_back(fixed_body(1, 32'h18000, 0, 32'hffff0000, 0, 32'h10000, 65536,
                                  32'h10000));
    // far corners, wide difference path
    bodies_q.push_back(fixed_body(0, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h80000000, 32'hffffffff, 17'h1ffff, 31'h7fffffff));
    bodies_q.push_back(fixed_body(1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                  32'h7fffffff, 32'hffffffff, 17'h1ffff, 31'h7fffffff));
    // huge radii on one axis, saturating velocities
    bodies_q.push_back(fixed_body(0, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 1, 65536,
                                  31'h7fffffff));
    bodies_q.push_back(fixed_body(1, 32'h7fffffff, 32'h1, 32'h80000000, 32'h80000000,
                                  32'hffffffff, 65536, 31'h7fffffff));
    // replaced A then contact, zero radius B
    bodies_q.push_back(fixed_body(0, 32'h100000, 0, 0, 0, 32'h10000, 0, 0));
    bodies_q.push_back(fixed_body(0, 0, 32'h8000, 32'hfff00000, 32'h300000, 32'h1, 0,
                                  32'h20000));
    bodies_q.push_back(fixed_body(1, 32'h8000, 0, 32'h100000, 32'hffe00000, 0, 32768, 0));
    // touching exactly: no overlap
    bodies_q.push_back(fixed_body(0, 0, 0, 32'h10000, 0, 32'h10000, 65536, 32'h10000));
    bodies_q.push_back(fixed_body(1, 32'h20000, 0, 0, 0, 32'h10000, 65536, 32'h10000));
    // lone B after release
    bodies_q.push_back(fixed_body(1, 32'h7fffffff, 32'h80000000, 0, 32'hffffffff, 0, 0,
                                  31'h7fffffff));
    while (bodies_q.size() < 850) begin
      k = $urandom_range(0, 19);
      cx = $urandom_range(0, 7) == 0 ? $urandom() : rnd_coord(0, 1 << 22);
      cy = $urandom_range(0, 7) == 0 ? $urandom() : rnd_coord(0, 1 << 22);
      if (k == 0) begin
        bodies_q.push_back(rnd_body(1, cx, cy));
      end else if (k == 1) begin
        bodies_q.push_back(rnd_body(0, cx, cy));
      end else begin
        bodies_q.push_back(rnd_body(0, cx, cy));
        bodies_q.push_back(rnd_body(1, cx, cy));
      end
    end
    total_bodies = bodies_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (bodies_q.size() == 0 && !in_valid && contacts_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && contacts_q.size() == 0) begin
      $display("** circle_collision_response: PASSED **");
    end else begin
      $display("** circle_collision_response: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** circle_collision_response: FAILED **");
    $finish;
  end

  // idle profile follows progress through the request list
  always @(posedge clk) begin
    case (sent_bodies * 4 / total_bodies)
      0: begin src_idle_pct <= 0; snk_stall_pct <= 0; end
      1: begin src_idle_pct <= 73; snk_stall_pct <= 0; end
      2: begin src_idle_pct <= 0; snk_stall_pct <= 73; end
      default: begin src_idle_pct <= 25; snk_stall_pct <= 25; end
    endcase
  end

  // request driver
  always @(posedge clk) begin
    body_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resolve_contact('{in_second_of_pair, in_pos_x, in_pos_y, in_vel_x, in_vel_y,
                          in_mass, in_bounce, in_radius});
        sent_bodies <= sent_bodies + 1;
      end
      if (!in_valid || in_ready) begin
        if (bodies_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          b = bodies_q.pop_front();
          in_valid <= 1'b1;
          in_second_of_pair <= b.second;
          in_pos_x <= b.px; in_pos_y <= b.py;
          in_vel_x <= b.vx; in_vel_y <= b.vy;
          in_mass <= b.mass; in_bounce <= b.bounce; in_radius <= b.radius;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    contact_t c;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= snk_stall_pct;
      if (out_valid && out_ready) begin
        if (contacts_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result body %0d", out_body_select);
        end else begin
          c = contacts_q.pop_front();
          if (out_body_select !== c.sel || out_new_pos_x !== c.px ||
              out_new_pos_y !== c.py || out_new_vel_x !== c.vx ||
              out_new_vel_y !== c.vy || out_collided !== c.hit ||
              out_last_result !== c.last) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch exp %0d %h %h %h %h %0d %0d got %0d %h %h %h %h %0d %0d",
                       c.sel, c.px, c.py, c.vx, c.vy, c.hit, c.last,
                       out_body_select, out_new_pos_x, out_new_pos_y, out_new_vel_x,
                       out_new_vel_y, out_collided, out_last_result);
          end
        end
      end
    end
  end

endmodule
